### hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int COUNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_COUNT_W  = 5;
   localparam int PAYLOAD_W      = 8;
   localparam int PRIORITY_W     = 32;
   localparam int STATUS_W       = 2;

   // Request codes.
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [PAYLOAD_W-1:0]  payload;
      logic [PRIORITY_W-1:0] prio;
   } spq_entry_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic          shift_en;
      logic          is_pop;
      spq_entry_type item;
   } spq_ctrl_type;

endpackage

### hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades with its neighbors.
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::spq_ctrl_type  ctrl,
   input  logic                   occupied,
   input  logic                   left_keep,
   input  spq_pkg::spq_entry_type left_entry,
   input  spq_pkg::spq_entry_type right_entry,
   output spq_pkg::spq_entry_type cur_entry,
   output logic                   keep,
   output spq_pkg::spq_entry_type next_entry
);

   spq_pkg::spq_entry_type entry_ff;
   spq_pkg::spq_entry_type entry_in;

   // A stored entry stays put on a push when it ranks at or above the new one.
   assign keep = occupied && (entry_ff.prio >= ctrl.item.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_en) begin
         if (ctrl.is_pop) begin
            entry_in = right_entry;
         end else if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = ctrl.item;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cur_entry  = entry_ff;
   assign next_entry = entry_in;

endmodule

### hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of slot cells plus a response register.
// A result beat is registered and shows in the cycle after its request beat is taken.
// Throughput: one request beat per cycle unless a result waits on the consumer;
// each cell decides from one compare of its own entry and its left neighbor's keep bit.
// Reset (synchronous, active high) empties the queue and drops any pending result beat;
// slot contents are not cleared, since only slots below the fill count are ever read.
module sorted_priority_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_type,
   input  logic [spq_pkg::PAYLOAD_W-1:0]           req_item_payload,
   input  logic [spq_pkg::PRIORITY_W-1:0]          req_item_priority,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [spq_pkg::STATUS_W-1:0]            rsp_result_status,
   output logic                                    rsp_head_valid,
   output logic [spq_pkg::PAYLOAD_W-1:0]           rsp_head_payload,
   output logic [spq_pkg::PRIORITY_W-1:0]          rsp_head_priority,
   output logic [spq_pkg::ENTRY_COUNT_W-1:0]       rsp_entry_count
);

   localparam int DEPTH = spq_pkg::QUEUE_DEPTH;

   // Fill count of the chain; slot i holds a live entry when i is below it.
   logic [spq_pkg::COUNT_W-1:0] count_ff;
   logic [spq_pkg::COUNT_W-1:0] count_in;

   // Registered result beat.
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [spq_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [spq_pkg::STATUS_W-1:0]     rsp_status_in;
   logic                             rsp_head_valid_ff;
   logic                             rsp_head_valid_in;
   spq_pkg::spq_entry_type           rsp_head_ff;
   spq_pkg::spq_entry_type           rsp_head_in;
   logic [spq_pkg::COUNT_W-1:0]      rsp_count_ff;

   logic req_fire;
   logic is_full;
   logic is_empty;
   logic do_push;
   logic do_pop;

   spq_pkg::spq_ctrl_type  ctrl;
   spq_pkg::spq_entry_type cell_cur  [DEPTH];
   spq_pkg::spq_entry_type cell_next [DEPTH];
   logic                   cell_keep [DEPTH];

   // A new request beat is taken whenever the result register is free or being drained,
   // so a waiting result never blocks the next request by more than the consumer's stall.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign is_full  = (count_ff == spq_pkg::COUNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // A push into a full queue and a pop on an empty queue leave the chain untouched.
   assign do_push = req_fire && (req_type == spq_pkg::REQ_PUSH) && !is_full;
   assign do_pop  = req_fire && (req_type == spq_pkg::REQ_POP) && !is_empty;

   always_comb begin
      ctrl.shift_en     = do_push || do_pop;
      ctrl.is_pop       = (req_type == spq_pkg::REQ_POP);
      ctrl.item.payload = req_item_payload;
      ctrl.item.prio    = req_item_priority;
   end

   // The chain: on a push every cell either keeps its entry, takes the new item (when it
   // is the first cell that ranks below the item) or takes its left neighbor's entry.
   // Equal priorities keep their place, so the newer item lands behind them.
   // On a pop every cell takes its right neighbor's entry.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::spq_entry_type left_entry;
      spq_pkg::spq_entry_type right_entry;
      logic                   left_keep;
      logic                   occupied;

      assign occupied = (spq_pkg::COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = ctrl.item;
      end else begin : g_body
         assign left_keep  = cell_keep[i-1];
         assign left_entry = cell_cur[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_cur[i];
      end else begin : g_mid
         assign right_entry = cell_cur[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .cur_entry   (cell_cur[i]),
         .keep        (cell_keep[i]),
         .next_entry  (cell_next[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + spq_pkg::COUNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - spq_pkg::COUNT_W'(1);
      end
   end

   // The result describes the queue after the request, so it is taken from the
   // next-state values of the head cell and the count.
   always_comb begin
      rsp_status_in = spq_pkg::ST_DONE;
      if ((req_type == spq_pkg::REQ_PUSH) && is_full) begin
         rsp_status_in = spq_pkg::ST_FULL;
      end else if ((req_type == spq_pkg::REQ_POP) && is_empty) begin
         rsp_status_in = spq_pkg::ST_EMPTY;
      end
      rsp_head_valid_in = (count_in != '0);
      rsp_head_in       = rsp_head_valid_in ? cell_next[0] : '0;
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_head_valid_ff <= rsp_head_valid_in;
         rsp_head_ff       <= rsp_head_in;
         rsp_count_ff      <= count_in;
      end
   end

   // The count port is five bits wide whatever the depth; widen first, then cut.
   logic [spq_pkg::COUNT_W+spq_pkg::ENTRY_COUNT_W-1:0] rsp_count_wide;
   assign rsp_count_wide = {{spq_pkg::ENTRY_COUNT_W{1'b0}}, rsp_count_ff};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_status = rsp_status_ff;
   assign rsp_head_valid    = rsp_head_valid_ff;
   assign rsp_head_payload  = rsp_head_ff.payload;
   assign rsp_head_priority = rsp_head_ff.prio;
   assign rsp_entry_count   = rsp_count_wide[spq_pkg::ENTRY_COUNT_W-1:0];

   // The fill count never passes the depth of the chain.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::COUNT_W'(DEPTH))
      else $error("fill count above queue depth");

   // A pending result always describes the live state of the chain.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == count_ff))
      else $error("result count out of step with the chain");

   // The head cell never ranks below the second cell.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff >= spq_pkg::COUNT_W'(2)) |-> (cell_cur[0].prio >= cell_cur[1].prio))
      else $error("chain out of order at the head");

   // A pop on an empty queue is flagged and leaves the queue empty.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_type == spq_pkg::REQ_POP) && is_empty) |=>
         ((rsp_status_ff == spq_pkg::ST_EMPTY) && (count_ff == '0)))
      else $error("pop on empty queue not flagged");

endmodule
